// ----- hdl/sfrt_pkg.sv -----
// ----------------------------------------------------------------------------
// SPI frame register table package
// Shared types, command codes and the reset table of preloaded addresses.
// ----------------------------------------------------------------------------
package sfrt_pkg;

    localparam logic [1:0] CMD_KIND_WRITE = 2'b11;
    localparam logic [1:0] CMD_KIND_READ  = 2'b10;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_WRITE,
        KIND_READ
    } t_kind;

    // Search packet that walks along the chain of cells, one cell per cycle.
    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [15:0] addr;
        logic [31:0] data;
        logic        hit;
        logic        free_seen;
    } t_pkt;

    // Late claim of a free entry, broadcast when a write has missed everywhere.
    typedef struct packed {
        logic        en;
        logic [15:0] addr;
        logic [31:0] data;
    } t_commit;

    function automatic logic [15:0] preload_address(input int unsigned idx);
        logic [15:0] r;
        case (idx)
            1:       r = 16'h0004;
            2:       r = 16'h000C;
            3:       r = 16'h0010;
            4:       r = 16'h0014;
            5:       r = 16'h001C;
            6:       r = 16'h4018;
            default: r = 16'h0000;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/sfrt_frame_if.sv -----
// ----------------------------------------------------------------------------
// SPI frame channel
// Valid/ready channel carrying one decoded frame per transaction.
// ----------------------------------------------------------------------------
interface sfrt_frame_if;
    logic        valid;
    logic        ready;
    logic [7:0]  command;
    logic [15:0] address;
    logic [31:0] write_data;

    modport source (output valid, command, address, write_data, input ready);
    modport sink   (input valid, command, address, write_data, output ready);
endinterface

// ----- hdl/sfrt_result_if.sv -----
// ----------------------------------------------------------------------------
// SPI frame result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface sfrt_result_if;
    logic        valid;
    logic        ready;
    logic        read_valid;
    logic [31:0] read_data;
    logic        write_dropped;

    modport source (output valid, read_valid, read_data, write_dropped, input ready);
    modport sink   (input valid, read_valid, read_data, write_dropped, output ready);
endinterface

// ----- hdl/sfrt_cell.sv -----
// ----------------------------------------------------------------------------
// SPI frame register table cell
// Holds one address/value entry, checks the passing packet against it and
// hands the packet on to the next cell.
// ----------------------------------------------------------------------------
module sfrt_cell #(
    parameter int unsigned IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  sfrt_pkg::t_pkt    i_pkt,
    input  sfrt_pkg::t_commit i_commit,
    output sfrt_pkg::t_pkt    o_pkt
);

    logic [15:0]    r_addr;
    logic [31:0]    r_value;
    logic           r_claim;
    sfrt_pkg::t_pkt r_pkt;

    sfrt_pkg::t_pkt n_pkt;
    logic           n_claim;
    logic           w_match;
    logic           w_free;
    logic           w_write_hit;

    always_comb begin
        w_match     = (i_pkt.addr == r_addr);
        w_free      = (IDX != 0) && (r_addr == 16'h0000);
        n_pkt       = i_pkt;
        n_claim     = 1'b0;
        w_write_hit = 1'b0;
        if (!i_pkt.hit && w_match) begin
            if (i_pkt.kind == sfrt_pkg::KIND_WRITE) begin
                n_pkt.hit   = 1'b1;
                w_write_hit = 1'b1;
            end else if (i_pkt.kind == sfrt_pkg::KIND_READ) begin
                n_pkt.hit  = 1'b1;
                n_pkt.data = r_value;
            end
        end else if (!i_pkt.hit && !i_pkt.free_seen && w_free &&
                     i_pkt.kind == sfrt_pkg::KIND_WRITE) begin
            n_pkt.free_seen = 1'b1;
            n_claim         = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr      <= sfrt_pkg::preload_address(IDX);
            r_value     <= 32'h0;
            r_claim     <= 1'b0;
            r_pkt.valid <= 1'b0;
        end else begin
            if (i_adv) begin
                r_pkt <= n_pkt;
                if (i_pkt.valid) begin
                    r_claim <= n_claim;
                    if (w_write_hit) begin
                        r_value <= i_pkt.data;
                    end
                end
            end
            if (i_commit.en && r_claim) begin
                r_addr  <= i_commit.addr;
                r_value <= i_commit.data;
            end
        end
    end

    assign o_pkt = r_pkt;

endmodule

// ----- hdl/spi_frame_register_table.sv -----
// ----------------------------------------------------------------------------
// SPI frame register table
// Associative table of address/value pairs served by decoded SPI frames.
// ----------------------------------------------------------------------------
// Frames arrive on i_frame and each yields exactly one result on o_result.
// A frame is latched and then walks a row of TABLE_ENTRIES cells, one cell
// per cycle; each cell holds one entry and updates or answers as the frame
// passes. A write that misses everywhere claims the first free cell it
// passed, once the frame has left the last cell.
// The result is written to the output register once the frame has left the
// last cell of the row, and one frame is handled at a time, so a new frame
// is taken only after the last one has left the cell row.
// A finished result waits in the output register while the next frame is
// already accepted and searched. If the receiver stalls while a second
// result reaches the end of the row, the row holds still until the output
// register is taken.
// Reset empties the row and the output register and reloads the table with
// its preloaded addresses and zero values.
// ----------------------------------------------------------------------------
module spi_frame_register_table #(
    parameter int unsigned TABLE_ENTRIES = 16
) (
    input logic           i_clk,
    input logic           i_rst_n,
    sfrt_frame_if.sink    i_frame,
    sfrt_result_if.source o_result
);

    sfrt_pkg::t_pkt    r_in;
    sfrt_pkg::t_pkt    n_in;
    logic              r_busy;
    logic              r_out_valid;
    logic              r_out_read_valid;
    logic [31:0]       r_out_read_data;
    logic              r_out_write_dropped;

    sfrt_pkg::t_pkt    w_chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES:0] w_chain_valid;
    sfrt_pkg::t_pkt    w_end;
    sfrt_pkg::t_commit w_commit;
    logic              w_adv;
    logic              w_accept;
    logic              w_retire;

    assign i_frame.ready = !r_busy;
    assign w_accept      = i_frame.valid && !r_busy;
    assign w_end         = w_chain[TABLE_ENTRIES];
    assign w_adv         = !(w_end.valid && r_out_valid && !o_result.ready);
    assign w_retire      = w_end.valid && w_adv;
    assign w_chain[0]    = r_in;

    always_comb begin
        n_in           = '0;
        n_in.valid     = w_accept;
        n_in.addr      = i_frame.address;
        case (i_frame.command[6:5])
            sfrt_pkg::CMD_KIND_WRITE: begin
                n_in.kind = sfrt_pkg::KIND_WRITE;
                n_in.data = i_frame.write_data;
            end
            sfrt_pkg::CMD_KIND_READ: begin
                n_in.kind = sfrt_pkg::KIND_READ;
            end
            default: begin
                n_in.kind = sfrt_pkg::KIND_NONE;
            end
        endcase
    end

    always_comb begin
        w_commit.en   = w_retire && (w_end.kind == sfrt_pkg::KIND_WRITE) &&
                        !w_end.hit && w_end.free_seen;
        w_commit.addr = w_end.addr;
        w_commit.data = w_end.data;
    end

    genvar k;
    generate
        for (k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
            sfrt_cell #(
                .IDX (k)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_adv    (w_adv),
                .i_pkt    (w_chain[k]),
                .i_commit (w_commit),
                .o_pkt    (w_chain[k+1])
            );
        end
        for (k = 0; k <= TABLE_ENTRIES; k++) begin : g_valid
            assign w_chain_valid[k] = w_chain[k].valid;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.valid  <= 1'b0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_in <= n_in;
            end
            if (w_accept) begin
                r_busy <= 1'b1;
            end else if (w_retire) begin
                r_busy <= 1'b0;
            end
            if (w_retire) begin
                r_out_valid         <= 1'b1;
                r_out_read_valid    <= (w_end.kind == sfrt_pkg::KIND_READ);
                r_out_read_data     <= (w_end.kind == sfrt_pkg::KIND_READ) ?
                                       w_end.data : 32'h0;
                r_out_write_dropped <= (w_end.kind == sfrt_pkg::KIND_WRITE) &&
                                       !w_end.hit && !w_end.free_seen;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.read_valid    = r_out_read_valid;
    assign o_result.read_data     = r_out_read_data;
    assign o_result.write_dropped = r_out_write_dropped;

    a_single_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_chain_valid))
        else $error("more than one frame in the cell row");

    a_idle_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_frame.ready |-> (w_chain_valid == '0))
        else $error("frame accepted while the cell row is busy");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_in.valid)
        else $error("accepted frame did not enter the cell row");

    a_retire_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_retire |=> (!r_busy && r_out_valid))
        else $error("retired frame did not reach the output register");

    a_drop_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_write_dropped) |->
            (!r_out_read_valid && r_out_read_data == 32'h0))
        else $error("dropped write reported with read data");

endmodule
